// ===== src/apt_pkg.sv =====
// ---------------------------------------------------------------------------
// Altitude PID thrust package
// Shared widths, fixed-point constants, register codes, datapath command and
// status types, and the saturation helper used by the altitude controller.
// ---------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

    // Fixed-point format of all internal values.
    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    // Field widths.
    localparam int IN_W     = 32;
    localparam int COS_W    = 16;
    localparam int COS_FRAC = 14;
    localparam int GAIN_W   = 31;
    localparam int TS_W     = 17;

    // Multiplier and divider widths.
    localparam int PROD_W  = DATA_WIDTH + GAIN_W;
    localparam int SHR_W   = PROD_W - FRAC_BITS;
    localparam int DIV_N_W = DATA_WIDTH + FRAC_BITS;
    localparam int DIV_D_W = TS_W;

    // Configuration port.
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [DATA_WIDTH+2:0] acc_t;

    localparam data_t D_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam data_t D_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

    // Gravity, 9.81 rounded to nearest at FRAC_BITS fraction bits.
    localparam longint GRAVITY_RAW = (981 * (64'sd1 <<< FRAC_BITS) + 50) / 100;
    localparam data_t  GRAVITY     = data_t'(GRAVITY_RAW);

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] MASS_RESET  = GAIN_W'(65536);
    localparam logic [TS_W-1:0]   TS_RESET    = TS_W'(655);
    localparam logic [GAIN_W-1:0] CLIMB_RESET = GAIN_W'(6553600);

    typedef enum logic [2:0] {
        REG_KP    = 3'd0,
        REG_KV    = 3'd1,
        REG_KI    = 3'd2,
        REG_MASS  = 3'd3,
        REG_TS    = 3'd4,
        REG_CLIMB = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kv;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] mass;
        logic [TS_W-1:0]   ts;
        logic [GAIN_W-1:0] climb;
    } cfg_t;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_TS   = 3'd0,
        MUL_KP   = 3'd1,
        MUL_KV   = 3'd2,
        MUL_KI   = 3'd3,
        MUL_MASS = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     bdiv_start;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     integ_upd;
        logic     acc_init;
        logic     acc_add;
        logic     num_load;
        logic     qdiv_start;
        logic     clamp_load;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic tilt_zero;
        logic bdiv_done;
        logic qdiv_done;
    } dp_stat_t;

    function automatic data_t sat_acc(input acc_t v);
        if (v > acc_t'(D_MAX))
        begin
            return D_MAX;
        end
        else if (v < acc_t'(D_MIN))
        begin
            return D_MIN;
        end
        return data_t'(v);
    endfunction

endpackage

`default_nettype wire

// ===== src/apt_in_if.sv =====
// ---------------------------------------------------------------------------
// Altitude sample channel
// Valid/ready channel that carries one altitude sample word.
// ---------------------------------------------------------------------------
`default_nettype none

interface apt_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [apt_pkg::IN_W-1:0]     target_height;
    logic signed [apt_pkg::IN_W-1:0]     target_vert_speed;
    logic signed [apt_pkg::IN_W-1:0]     measured_height;
    logic signed [apt_pkg::IN_W-1:0]     measured_vert_speed;
    logic signed [apt_pkg::COS_W-1:0]    vertical_axis_cos;
    logic signed [apt_pkg::IN_W-1:0]     feedforward_accel;

    modport source (
        output valid,
        input  ready,
        output target_height,
        output target_vert_speed,
        output measured_height,
        output measured_vert_speed,
        output vertical_axis_cos,
        output feedforward_accel
    );

    modport sink (
        input  valid,
        output ready,
        input  target_height,
        input  target_vert_speed,
        input  measured_height,
        input  measured_vert_speed,
        input  vertical_axis_cos,
        input  feedforward_accel
    );

endinterface

`default_nettype wire

// ===== src/apt_out_if.sv =====
// ---------------------------------------------------------------------------
// Thrust command channel
// Valid/ready channel that carries one thrust command word.
// ---------------------------------------------------------------------------
`default_nettype none

interface apt_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [apt_pkg::IN_W-1:0]     thrust_cmd;
    logic                                clamp_hit;
    logic                                tilt_fault;

    modport source (
        output valid,
        input  ready,
        output thrust_cmd,
        output clamp_hit,
        output tilt_fault
    );

    modport sink (
        input  valid,
        output ready,
        input  thrust_cmd,
        input  clamp_hit,
        input  tilt_fault
    );

endinterface

`default_nettype wire

// ===== src/apt_regs.sv =====
// ---------------------------------------------------------------------------
// Altitude PID configuration registers
// APB-style register file holding gains, mass, step length and climb limit.
// ---------------------------------------------------------------------------
`default_nettype none

module apt_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [apt_pkg::PDATA_W-1:0]   pwdata,
    output      logic [apt_pkg::PDATA_W-1:0]   prdata,
    output      apt_pkg::cfg_t                 cfg
);

    apt_pkg::cfg_t     cfg_reg;
    apt_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = apt_pkg::reg_idx_t'(paddr[apt_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp    <= '0;
            cfg_reg.kv    <= '0;
            cfg_reg.ki    <= '0;
            cfg_reg.mass  <= apt_pkg::MASS_RESET;
            cfg_reg.ts    <= apt_pkg::TS_RESET;
            cfg_reg.climb <= apt_pkg::CLIMB_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                apt_pkg::REG_KP:    cfg_reg.kp    <= pwdata[apt_pkg::GAIN_W-1:0];
                apt_pkg::REG_KV:    cfg_reg.kv    <= pwdata[apt_pkg::GAIN_W-1:0];
                apt_pkg::REG_KI:    cfg_reg.ki    <= pwdata[apt_pkg::GAIN_W-1:0];
                apt_pkg::REG_MASS:  cfg_reg.mass  <= pwdata[apt_pkg::GAIN_W-1:0];
                apt_pkg::REG_TS:    cfg_reg.ts    <= pwdata[apt_pkg::TS_W-1:0];
                apt_pkg::REG_CLIMB: cfg_reg.climb <= pwdata[apt_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            apt_pkg::REG_KP:    prdata = apt_pkg::PDATA_W'(cfg_reg.kp);
            apt_pkg::REG_KV:    prdata = apt_pkg::PDATA_W'(cfg_reg.kv);
            apt_pkg::REG_KI:    prdata = apt_pkg::PDATA_W'(cfg_reg.ki);
            apt_pkg::REG_MASS:  prdata = apt_pkg::PDATA_W'(cfg_reg.mass);
            apt_pkg::REG_TS:    prdata = apt_pkg::PDATA_W'(cfg_reg.ts);
            apt_pkg::REG_CLIMB: prdata = apt_pkg::PDATA_W'(cfg_reg.climb);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/apt_div.sv =====
// ---------------------------------------------------------------------------
// Altitude PID unsigned divider
// Restoring divider that retires two quotient bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module apt_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [apt_pkg::DIV_N_W-1:0]   dividend,
    input  wire logic [apt_pkg::DIV_D_W-1:0]   divisor,
    output      logic [apt_pkg::DIV_N_W-1:0]   quotient,
    output      logic                          done
);

    localparam int N     = apt_pkg::DIV_N_W;
    localparam int D     = apt_pkg::DIV_D_W;
    localparam int STEPS = N / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [N-1:0]     shift_reg;
    logic [N-1:0]     shift_next;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     rem_next;
    logic [D-1:0]     dvsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [D:0]       r1;
    logic [D:0]       r1_sub;
    logic [D:0]       r2;
    logic [D:0]       r2_sub;
    logic             ge1;
    logic             ge2;

    // Two restoring steps: each shifts in one dividend bit and subtracts
    // the divisor when the partial remainder allows it.
    always_comb
    begin
        r1       = {rem_reg, shift_reg[N-1]};
        ge1      = (r1 >= {1'b0, dvsr_reg});
        r1_sub   = ge1 ? (r1 - {1'b0, dvsr_reg}) : r1;
        r2       = {r1_sub[D-1:0], shift_reg[N-2]};
        ge2      = (r2 >= {1'b0, dvsr_reg});
        r2_sub   = ge2 ? (r2 - {1'b0, dvsr_reg}) : r2;
        rem_next   = r2_sub[D-1:0];
        shift_next = {shift_reg[N-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign quotient = shift_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== src/apt_datapath.sv =====
// ---------------------------------------------------------------------------
// Altitude PID datapath
// Error registers, integrator, shared fixed-point multiplier, PID
// accumulator, two dividers, clamp and thrust output register.
// ---------------------------------------------------------------------------
`default_nettype none

module apt_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire apt_pkg::cfg_t                     cfg,
    input  wire apt_pkg::dp_cmd_t                  cmd,
    output      apt_pkg::dp_stat_t                 stat,
    input  wire apt_pkg::data_t                    target_height,
    input  wire apt_pkg::data_t                    target_vert_speed,
    input  wire apt_pkg::data_t                    measured_height,
    input  wire apt_pkg::data_t                    measured_vert_speed,
    input  wire logic signed [apt_pkg::COS_W-1:0]  vertical_axis_cos,
    input  wire apt_pkg::data_t                    feedforward_accel,
    output      apt_pkg::data_t                    thrust_cmd,
    output      logic                              clamp_hit,
    output      logic                              tilt_fault
);

    localparam int DW = apt_pkg::DATA_WIDTH;
    localparam int FB = apt_pkg::FRAC_BITS;
    localparam int CW = apt_pkg::COS_W;
    localparam int NW = apt_pkg::DIV_N_W;

    apt_pkg::data_t                herr_reg;
    apt_pkg::data_t                verr_reg;
    apt_pkg::data_t                ff_reg;
    logic signed [CW-1:0]          r22_reg;
    apt_pkg::data_t                integ_reg;
    logic [apt_pkg::PROD_W-1:0]    prod_reg;
    logic                          neg_reg;
    apt_pkg::acc_t                 acc_reg;
    apt_pkg::data_t                num_reg;
    apt_pkg::data_t                num_next;
    apt_pkg::data_t                c_reg;
    apt_pkg::data_t                c_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          fault_reg;
    apt_pkg::data_t                thrust_reg;
    logic                          clamp_reg;
    logic                          tilt_reg;

    apt_pkg::data_t                mul_a;
    logic [apt_pkg::GAIN_W-1:0]    mul_b;
    logic [DW-1:0]                 mul_mag;
    logic [apt_pkg::SHR_W-1:0]     shr;
    logic [DW-1:0]                 shr_lo;
    logic                          pos_over;
    logic                          neg_over;
    apt_pkg::data_t                mulq;

    logic [DW-1:0]                 num_mag;
    logic [CW-1:0]                 r22_mag;
    logic [NW-1:0]                 bquot;
    logic [NW-1:0]                 qquot;
    logic                          bdiv_done;
    logic                          qdiv_done;
    logic [DW-1:0]                 bound_mag;
    logic [DW-1:0]                 c_mag;
    logic                          q_over;
    logic                          q_neg;
    apt_pkg::data_t                u_sat;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            apt_pkg::MUL_TS:
            begin
                mul_a = herr_reg;
                mul_b = apt_pkg::GAIN_W'(cfg.ts);
            end
            apt_pkg::MUL_KP:
            begin
                mul_a = herr_reg;
                mul_b = cfg.kp;
            end
            apt_pkg::MUL_KV:
            begin
                mul_a = verr_reg;
                mul_b = cfg.kv;
            end
            apt_pkg::MUL_KI:
            begin
                mul_a = integ_reg;
                mul_b = cfg.ki;
            end
            apt_pkg::MUL_MASS:
            begin
                mul_a = c_reg;
                mul_b = cfg.mass;
            end
            default:
            begin
                mul_a = herr_reg;
                mul_b = '0;
            end
        endcase
        mul_mag = mul_a[DW-1] ? ('0 - $unsigned(mul_a)) : $unsigned(mul_a);
    end

    // Scale the registered product back by FRAC_BITS, truncating toward zero
    // on the magnitude, then apply the sign and saturate.
    always_comb
    begin
        shr      = prod_reg[apt_pkg::PROD_W-1:FB];
        shr_lo   = shr[DW-1:0];
        pos_over = |shr[apt_pkg::SHR_W-1:DW-1];
        neg_over = (|shr[apt_pkg::SHR_W-1:DW]) || (shr[DW-1] && (|shr[DW-2:0]));
        if (neg_reg)
        begin
            mulq = neg_over ? apt_pkg::D_MIN : apt_pkg::data_t'('0 - shr_lo);
        end
        else
        begin
            mulq = pos_over ? apt_pkg::D_MAX : apt_pkg::data_t'(shr_lo);
        end
    end

    // PID sum less gravity.
    always_comb
    begin
        u_sat    = apt_pkg::sat_acc(acc_reg);
        num_next = apt_pkg::sat_acc(apt_pkg::acc_t'(u_sat) -
                                    apt_pkg::acc_t'(apt_pkg::GRAVITY));
    end

    assign num_mag = num_reg[DW-1] ? ('0 - $unsigned(num_reg)) : $unsigned(num_reg);
    assign r22_mag = r22_reg[CW-1] ? ('0 - $unsigned(r22_reg)) : $unsigned(r22_reg);

    apt_div u_bound_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.bdiv_start),
        .dividend (NW'({cfg.climb, {FB{1'b0}}})),
        .divisor  (cfg.ts),
        .quotient (bquot),
        .done     (bdiv_done)
    );

    apt_div u_quot_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.qdiv_start),
        .dividend (NW'({num_mag, {apt_pkg::COS_FRAC{1'b0}}})),
        .divisor  (apt_pkg::DIV_D_W'(r22_mag)),
        .quotient (qquot),
        .done     (qdiv_done)
    );

    // Clamp of the tilt-compensated value to the symmetric climb bound.
    always_comb
    begin
        if (cfg.ts == '0)
        begin
            bound_mag = apt_pkg::D_MAX;
        end
        else if (|bquot[NW-1:DW-1])
        begin
            bound_mag = apt_pkg::D_MAX;
        end
        else
        begin
            bound_mag = {1'b0, bquot[DW-2:0]};
        end

        q_neg  = num_reg[DW-1] ^ r22_reg[CW-1];
        q_over = (qquot > NW'(bound_mag));
        c_mag  = q_over ? bound_mag : qquot[DW-1:0];

        if (stat.tilt_zero)
        begin
            c_next   = num_reg[DW-1] ? apt_pkg::data_t'('0 - bound_mag)
                                     : apt_pkg::data_t'(bound_mag);
            hit_next = 1'b1;
        end
        else
        begin
            c_next   = q_neg ? apt_pkg::data_t'('0 - c_mag) : apt_pkg::data_t'(c_mag);
            hit_next = q_over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (cmd.integ_upd)
        begin
            integ_reg <= apt_pkg::sat_acc(apt_pkg::acc_t'(integ_reg) +
                                          apt_pkg::acc_t'(mulq));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            herr_reg <= apt_pkg::sat_acc(apt_pkg::acc_t'(target_height) -
                                         apt_pkg::acc_t'(measured_height));
            verr_reg <= apt_pkg::sat_acc(apt_pkg::acc_t'(target_vert_speed) -
                                         apt_pkg::acc_t'(measured_vert_speed));
            ff_reg   <= feedforward_accel;
            r22_reg  <= vertical_axis_cos;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= apt_pkg::PROD_W'(mul_mag) * apt_pkg::PROD_W'(mul_b);
            neg_reg  <= mul_a[DW-1];
        end
        if (cmd.acc_init)
        begin
            acc_reg <= apt_pkg::acc_t'(ff_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + apt_pkg::acc_t'(mulq);
        end
        if (cmd.num_load)
        begin
            num_reg <= num_next;
        end
        if (cmd.clamp_load)
        begin
            c_reg     <= c_next;
            hit_reg   <= hit_next;
            fault_reg <= stat.tilt_zero;
        end
        if (cmd.out_load)
        begin
            thrust_reg <= apt_pkg::sat_acc(apt_pkg::acc_t'(0) - apt_pkg::acc_t'(mulq));
            clamp_reg  <= hit_reg;
            tilt_reg   <= fault_reg;
        end
    end

    assign stat.tilt_zero = (r22_reg == '0);
    assign stat.bdiv_done = bdiv_done;
    assign stat.qdiv_done = qdiv_done;

    assign thrust_cmd = thrust_reg;
    assign clamp_hit  = clamp_reg;
    assign tilt_fault = tilt_reg;

endmodule

`default_nettype wire

// ===== src/apt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Altitude PID controller
// Sequences one sample word through the datapath and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module apt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    input  wire apt_pkg::dp_stat_t stat,
    output      apt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_TS,
        S_INTEG,
        S_MUL_KV,
        S_MUL_KI,
        S_ACC_I,
        S_NUM,
        S_QDIV,
        S_WAIT,
        S_CLAMP,
        S_MUL_M,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = apt_pkg::MUL_TS;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.bdiv_start = 1'b1;
                    state_next     = S_MUL_TS;
                end
            end
            S_MUL_TS:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = apt_pkg::MUL_TS;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                // Integrator takes err*step while the P product starts.
                cmd.integ_upd = 1'b1;
                cmd.acc_init  = 1'b1;
                cmd.mul_go    = 1'b1;
                cmd.mul_sel   = apt_pkg::MUL_KP;
                state_next    = S_MUL_KV;
            end
            S_MUL_KV:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = apt_pkg::MUL_KV;
                state_next  = S_MUL_KI;
            end
            S_MUL_KI:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = apt_pkg::MUL_KI;
                state_next  = S_ACC_I;
            end
            S_ACC_I:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_NUM;
            end
            S_NUM:
            begin
                cmd.num_load = 1'b1;
                state_next   = S_QDIV;
            end
            S_QDIV:
            begin
                // A zero cosine skips the division and takes the bound.
                cmd.qdiv_start = !stat.tilt_zero;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.bdiv_done && (stat.tilt_zero || stat.qdiv_done))
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp_load = 1'b1;
                state_next     = S_MUL_M;
            end
            S_MUL_M:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = apt_pkg::MUL_MASS;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/altitude_pid_thrust_core.sv =====
// ---------------------------------------------------------------------------
// A new sample word is accepted only after the previous one has been loaded
// into the output register. A zero vertical-axis cosine skips the quotient
// division that follows the PID sum, so such a word passes through sooner.
// Reset: rst_n clears the integrator, the sequencer and output valid, and
// loads the configuration registers with their reset values.
// ---------------------------------------------------------------------------
// Altitude PID thrust core
// Tilt-compensated PID altitude controller with a climb clamp, a sequencer
// driving a shared multiplier and two radix-4 dividers, and an APB-style
// configuration port.
// ---------------------------------------------------------------------------
`default_nettype none

module altitude_pid_thrust_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Configuration port. pready is tied high; a write lands on the access
    // cycle. Register i sits at byte address 4*i.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [apt_pkg::PDATA_W-1:0]   pwdata,
    output      logic [apt_pkg::PDATA_W-1:0]   prdata,
    output      logic                          pready,

    // Sample words in, thrust words out.
    apt_in_if.sink                             sample,
    apt_out_if.source                          command
);

    apt_pkg::cfg_t     cfg;
    apt_pkg::dp_cmd_t  cmd;
    apt_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    // Gains, mass, step and climb limit. The block only reads them while a
    // word is in flight, so software writes them between words.
    apt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The sequencer accepts a sample only when idle. The finished thrust word
    // sits in an output register, so the next sample is taken while the
    // previous word still waits for the consumer; the sequencer only holds in
    // its last state if a new result is ready before the old one is taken.
    apt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (command.valid),
        .out_ready (command.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath forms the height and speed errors on acceptance, updates
    // the integrator with err*step, accumulates the three gain products and
    // feed-forward, removes gravity, divides by R22 (Q2.14) and clamps to
    // +-(climb_limit / time_step). The bound division starts at acceptance
    // and runs beside the PID sequence. The clamped value times minus the
    // mass gives the thrust word. A zero R22 takes the bound with the sign of
    // the numerator and raises both flags.
    apt_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .cmd                 (cmd),
        .stat                (stat),
        .target_height       (sample.target_height),
        .target_vert_speed   (sample.target_vert_speed),
        .measured_height     (sample.measured_height),
        .measured_vert_speed (sample.measured_vert_speed),
        .vertical_axis_cos   (sample.vertical_axis_cos),
        .feedforward_accel   (sample.feedforward_accel),
        .thrust_cmd          (command.thrust_cmd),
        .clamp_hit           (command.clamp_hit),
        .tilt_fault          (command.tilt_fault)
    );

endmodule

`default_nettype wire

// ===== tb/sv/altitude_pid_thrust_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Altitude PID thrust core testbench
// Feeds altitude sample words through the valid/ready input channel and
// checks every thrust word against a cycle-free predictor of the controller:
// integrator, PID sum, gravity removal, tilt division, climb clamp and mass
// scaling. The gains are reprogrammed over the APB port between phases, and
// both channels idle and stall at random.
// ---------------------------------------------------------------------------

module altitude_pid_thrust_core_test;

    // Saturation bounds and gravity in the predictor's 64-bit arithmetic.
    localparam longint WORD_MAX = longint'(apt_pkg::D_MAX);
    localparam longint WORD_MIN = longint'(apt_pkg::D_MIN);
    localparam longint GRAV_Q   = longint'(apt_pkg::GRAVITY);

    // Register indexes that the block does not decode; writes must be dropped.
    localparam logic [2:0] SPARE_REG_LO = 3'd6;
    localparam logic [2:0] SPARE_REG_HI = 3'd7;

    // Longest stretch without any accepted word or register write. The slowest
    // correct stretch is the receiver hold-off plus one block latency and the
    // longest idle bursts, so this leaves a wide margin.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [31:0] tgt_h;
        logic signed [31:0] tgt_v;
        logic signed [31:0] meas_h;
        logic signed [31:0] meas_v;
        logic signed [15:0] cosr;
        logic signed [31:0] ff;
    } sample_t;

    typedef struct {
        logic signed [31:0] thrust;
        logic               clamp;
        logic               fault;
    } thrust_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [apt_pkg::ADDR_W-1:0]  paddr;
    logic [apt_pkg::PDATA_W-1:0] pwdata;
    logic [apt_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    apt_in_if  sample_bus ();
    apt_out_if thrust_bus ();

    altitude_pid_thrust_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_bus),
        .command (thrust_bus)
    );

    // Predictor copy of the configuration registers, at their real widths.
    logic [apt_pkg::GAIN_W-1:0] gain_kp;
    logic [apt_pkg::GAIN_W-1:0] gain_kv;
    logic [apt_pkg::GAIN_W-1:0] gain_ki;
    logic [apt_pkg::GAIN_W-1:0] mass_q;
    logic [apt_pkg::TS_W-1:0]   step_q;
    logic [apt_pkg::GAIN_W-1:0] climb_q;

    // Predictor copy of the height-error integrator.
    longint err_integral;

    sample_t pending_samples[$];
    thrust_t expected_thrust[$];
    sample_t word_on_bus;

    int  mismatch_count = 0;
    int  words_in = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clip(input logic signed [127:0] v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return longint'(v[63:0]);
    endfunction

    // Full-precision product of a value and a register, scaled down by the
    // fraction bits with truncation toward zero, then saturated.
    function automatic longint gain_mul(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        logic signed [127:0] mag;
        wa = a;
        wb = b;
        p = wa * wb;
        mag = (p < 0) ? -p : p;
        mag = mag >> apt_pkg::FRAC_BITS;
        return clip((p < 0) ? -mag : mag);
    endfunction

    // Works out the thrust word for one accepted sample and advances the
    // integrator, exactly once per accepted word.
    function automatic thrust_t predict_thrust(input sample_t s);
        longint  herr;
        longint  verr;
        longint  pid;
        longint  num;
        longint  bound;
        longint  quot;
        thrust_t t;
        herr = clip(longint'(s.tgt_h) - longint'(s.meas_h));
        err_integral = clip(err_integral + gain_mul(herr, longint'(step_q)));
        verr = clip(longint'(s.tgt_v) - longint'(s.meas_v));
        pid = clip(gain_mul(herr, longint'(gain_kp)) + gain_mul(verr, longint'(gain_kv))
                   + gain_mul(err_integral, longint'(gain_ki)) + longint'(s.ff));
        num = clip(pid - GRAV_Q);

        // A zero step leaves the climb bound wide open.
        if (step_q == 0)
        begin
            bound = WORD_MAX;
        end
        else
        begin
            bound = clip((longint'(climb_q) <<< apt_pkg::FRAC_BITS) / longint'(step_q));
        end

        t.fault = (s.cosr == 0);
        t.clamp = t.fault;
        if (t.fault)
        begin
            // No division on a zero cosine: the sign of the numerator picks
            // the bound.
            quot = (num >= 0) ? bound : -bound;
        end
        else
        begin
            quot = (num * 16384) / longint'(s.cosr);
            if (quot > bound)
            begin
                quot = bound;
                t.clamp = 1'b1;
            end
            else if (quot < -bound)
            begin
                quot = -bound;
                t.clamp = 1'b1;
            end
        end
        t.thrust = 32'(clip(-gain_mul(quot, longint'(mass_q))));
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] spread(input int unsigned span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return 32'(apt_pkg::D_MAX);
            1: return 32'(apt_pkg::D_MIN);
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'd1;
            default: return 32'(apt_pkg::GRAVITY);
        endcase
    endfunction

    function automatic logic [15:0] corner_cos();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'd1;
            4: return 16'hFFFF;
            5: return 16'h8000;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Mostly flight-like samples, so the integrator and the clamp see long
    // coherent runs, with raw noise and corner values mixed in.
    function automatic sample_t random_sample();
        sample_t s;
        s.tgt_h  = spread(1 << 23);
        s.meas_h = s.tgt_h + spread(1 << 19);
        s.tgt_v  = spread(1 << 20);
        s.meas_v = s.tgt_v + spread(1 << 18);
        s.ff     = spread(1 << 20);
        s.cosr   = 16'(16384 - $urandom_range(0, 8000));
        if ($urandom_range(0, 9) == 0)
        begin
            s.cosr = -s.cosr;
        end
        case ($urandom_range(0, 19))
            12, 13, 14:
            begin
                s.tgt_h  = $urandom;
                s.tgt_v  = $urandom;
                s.meas_h = $urandom;
                s.meas_v = $urandom;
                s.ff     = $urandom;
                s.cosr   = 16'($urandom);
            end
            15, 16:
            begin
                s.tgt_h  = corner_value();
                s.tgt_v  = corner_value();
                s.meas_h = corner_value();
                s.meas_v = corner_value();
                s.ff     = corner_value();
                s.cosr   = corner_cos();
            end
            17: s.cosr = 16'd0;
            18: s.cosr = 16'(spread(64));
            default: ;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 1 << 18));
            3: return $urandom;
            default: return 32'($urandom_range(1 << 14, 1 << 17));
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($urandom_range(1 << 14, 1 << 22));
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd65536;
            3: return 32'h1_FFFF;
            4: return $urandom;
            5: return 32'($urandom_range(1, 65536));
            default: return 32'd655;
        endcase
    endfunction

    function automatic logic [31:0] pick_climb();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'($urandom_range(1 << 16, 1 << 24));
        endcase
    endfunction

    // One APB write: setup cycle, then access cycle. The register takes the
    // value at the edge that closes the access cycle, and so does the copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            apt_pkg::REG_KP:    gain_kp = value[apt_pkg::GAIN_W-1:0];
            apt_pkg::REG_KV:    gain_kv = value[apt_pkg::GAIN_W-1:0];
            apt_pkg::REG_KI:    gain_ki = value[apt_pkg::GAIN_W-1:0];
            apt_pkg::REG_MASS:  mass_q  = value[apt_pkg::GAIN_W-1:0];
            apt_pkg::REG_TS:    step_q  = value[apt_pkg::TS_W-1:0];
            apt_pkg::REG_CLIMB: climb_q = value[apt_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] kp, input logic [31:0] kv,
                                 input logic [31:0] ki, input logic [31:0] mass,
                                 input logic [31:0] step, input logic [31:0] climb);
        write_reg(apt_pkg::REG_KP, kp);
        write_reg(apt_pkg::REG_KV, kv);
        write_reg(apt_pkg::REG_KI, ki);
        write_reg(apt_pkg::REG_MASS, mass);
        write_reg(apt_pkg::REG_TS, step);
        write_reg(apt_pkg::REG_CLIMB, climb);
    endtask

    task automatic queue_word(input logic [31:0] th, input logic [31:0] tv,
                              input logic [31:0] mh, input logic [31:0] mv,
                              input logic [15:0] cosr, input logic [31:0] ff);
        sample_t s;
        s.tgt_h  = th;
        s.tgt_v  = tv;
        s.meas_h = mh;
        s.meas_v = mv;
        s.cosr   = cosr;
        s.ff     = ff;
        pending_samples.push_back(s);
    endtask

    // Blocks until every queued word went in and every thrust word came out.
    // The check runs on the falling edge, after the driver and the monitor
    // have settled. Each sample yields exactly one thrust word, so the core
    // is idle then; a few extra cycles are left before the next register
    // write anyway.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_bus.valid
               || expected_thrust.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit quiet);
        int n;
        if (quiet || $urandom_range(0, 3) == 0)
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
        else
        begin
            send_idle_pct <= $urandom_range(5, 60);
            recv_idle_pct <= $urandom_range(5, 60);
        end
        for (n = 0; n < count; n++)
        begin
            pending_samples.push_back(random_sample());
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sample driver: offers queued words, holds a word until it is taken,
    // and inserts random idle bursts between words.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_driver
        sample_t nxt;
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                expected_thrust.push_back(predict_thrust(word_on_bus));
                words_in <= words_in + 1;
            end
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    sample_bus.valid <= 1'b0;
                end
                else if ($urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap <= $urandom_range(0, 17);
                    sample_bus.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    nxt = pending_samples.pop_front();
                    word_on_bus <= nxt;
                    sample_bus.target_height       <= nxt.tgt_h;
                    sample_bus.target_vert_speed   <= nxt.tgt_v;
                    sample_bus.measured_height     <= nxt.meas_h;
                    sample_bus.measured_vert_speed <= nxt.meas_v;
                    sample_bus.vertical_axis_cos   <= nxt.cosr;
                    sample_bus.feedforward_accel   <= nxt.ff;
                    sample_bus.valid <= 1'b1;
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Thrust monitor: checks each accepted word against the oldest
    // prediction and drives ready with random stall bursts, or holds it
    // low for the whole pressure window.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : thrust_monitor
        thrust_t want;
        if (!rst_n)
        begin
            thrust_bus.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (thrust_bus.valid && thrust_bus.ready)
            begin
                if (expected_thrust.size() == 0)
                begin
                    report_mismatch($sformatf("thrust word %h with nothing expected",
                                              thrust_bus.thrust_cmd));
                end
                else
                begin
                    want = expected_thrust.pop_front();
                    if (thrust_bus.thrust_cmd !== want.thrust)
                    begin
                        report_mismatch($sformatf("thrust_cmd %h, expected %h",
                                                  thrust_bus.thrust_cmd, want.thrust));
                    end
                    if (thrust_bus.clamp_hit !== want.clamp)
                    begin
                        report_mismatch($sformatf("clamp_hit %b, expected %b",
                                                  thrust_bus.clamp_hit, want.clamp));
                    end
                    if (thrust_bus.tilt_fault !== want.fault)
                    begin
                        report_mismatch($sformatf("tilt_fault %b, expected %b",
                                                  thrust_bus.tilt_fault, want.fault));
                    end
                end
            end
            if (hold_off)
            begin
                thrust_bus.ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap <= recv_gap - 1;
                thrust_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_gap <= $urandom_range(0, 17);
                thrust_bus.ready <= 1'b0;
            end
            else
            begin
                thrust_bus.ready <= 1'b1;
            end
        end
    end

    // Back-pressure window: once the run is well under way the receiver stops
    // taking thrust words for a long stretch while the driver keeps offering
    // samples, so the core fills up and has to drop its input ready.
    initial
    begin
        wait (words_in >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: counts cycles in which neither channel moves a word and no
    // register write is in its access cycle.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready)
            || (thrust_bus.valid && thrust_bus.ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int k;

        // Every input of the core is known from time zero.
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sample_bus.valid               = 1'b0;
        sample_bus.target_height       = '0;
        sample_bus.target_vert_speed   = '0;
        sample_bus.measured_height     = '0;
        sample_bus.measured_vert_speed = '0;
        sample_bus.vertical_axis_cos   = '0;
        sample_bus.feedforward_accel   = '0;
        thrust_bus.ready               = 1'b0;

        gain_kp = '0;
        gain_kv = '0;
        gain_ki = '0;
        mass_q  = apt_pkg::MASS_RESET;
        step_q  = apt_pkg::TS_RESET;
        climb_q = apt_pkg::CLIMB_RESET;
        err_integral = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A few samples against the reset values of the registers.
        run_phase(3, 1'b0);

        // Directed part under hand-picked gains. The zero-error samples come
        // first, so the integrator holds what the opening samples left in it.
        load_settings(32'd131072, 32'd65536, 32'd32768, 32'd131072, 32'd655, 32'd6553600);
        write_reg(SPARE_REG_LO, 32'h5A5A_1234);
        write_reg(SPARE_REG_HI, 32'hFFFF_FFFF);
        queue_word(0, 0, 0, 0, 16'sd16384, 0);
        queue_word(0, 0, 0, 0, 16'd0, 0);                 // zero tilt, zero feed-forward
        queue_word(0, 0, 0, 0, 16'd0, 32'(apt_pkg::GRAVITY)); // zero tilt, feed-forward equal to gravity
        queue_word(0, 0, 0, 0, 16'd0, 32'(apt_pkg::D_MAX));
        queue_word(0, 0, 0, 0, 16'sd16384, 32'(apt_pkg::GRAVITY) + 32'd65536);
        queue_word(0, 0, 0, 0, -16'sd16384, 0);           // inverted vehicle
        queue_word(0, 0, 0, 0, 16'd1, 32'(apt_pkg::D_MAX)); // tiny cosine, clamp high
        queue_word(0, 0, 0, 0, 16'd1, 32'(apt_pkg::D_MIN)); // tiny cosine, clamp low
        queue_word(0, 0, 0, 0, 16'hFFFF, 32'(apt_pkg::D_MAX));
        queue_word(0, 0, 0, 0, 16'h8000, 32'(apt_pkg::GRAVITY) + 32'd1);
        queue_word(0, 0, 0, 0, 16'h7FFF, 32'(apt_pkg::D_MIN));
        queue_word(0, 32'(apt_pkg::D_MAX), 0, 32'(apt_pkg::D_MIN), 16'sd16384, 0);
        queue_word(0, 32'(apt_pkg::D_MIN), 0, 32'(apt_pkg::D_MAX), 16'sd16384, 0);
        queue_word(32'(apt_pkg::D_MAX), 0, 32'(apt_pkg::D_MIN), 0, 16'sd16384, 0);
        queue_word(32'(apt_pkg::D_MIN), 0, 32'(apt_pkg::D_MAX), 0, 16'sd16384, 0);
        queue_word(32'(apt_pkg::D_MAX), 32'(apt_pkg::D_MAX), 32'(apt_pkg::D_MAX),
                   32'(apt_pkg::D_MAX), 16'sd16384, 32'(apt_pkg::D_MAX));
        queue_word(32'(apt_pkg::D_MIN), 32'(apt_pkg::D_MIN), 32'(apt_pkg::D_MIN),
                   32'(apt_pkg::D_MIN), -16'sd16384, 32'(apt_pkg::D_MIN));
        queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF);
        queue_word(32'd1, 0, 0, 0, 16'sd8192, 0);
        send_idle_pct <= 20;
        recv_idle_pct <= 20;
        wait_idle();

        // Long flight-like run; the back-pressure window falls inside it.
        load_settings(32'd98304, 32'd49152, 32'd6554, 32'd98304, 32'd655, 32'd6553600);
        run_phase(200, 1'b0);

        // All-ones writes: every register at the top of its width, including a
        // step above one second.
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(50, 1'b0);

        // Largest in-range values.
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'd65536, 32'h7FFF_FFFF);
        run_phase(50, 1'b0);

        // Zero step: frozen integrator and an open climb bound.
        load_settings(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd6553600);
        run_phase(40, 1'b0);

        // Zero climb limit clamps every nonzero quotient; zero mass zeroes thrust.
        load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0);
        run_phase(40, 1'b0);

        for (k = 0; k < 4; k++)
        begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_mass(),
                          pick_step(), pick_climb());
            run_phase(70, 1'b0);
        end

        // Closing stretch at full rate on both sides.
        load_settings(32'd131072, 32'd65536, 32'd13107, 32'd78643, 32'd655, 32'd6553600);
        run_phase(100, 1'b1);

        // Anything the core still emits now is an unexpected word.
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/apt_pkg.sv
src/apt_in_if.sv
src/apt_out_if.sv
src/apt_regs.sv
src/apt_div.sv
src/apt_datapath.sv
src/apt_ctrl.sv
src/altitude_pid_thrust_core.sv
tb/sv/altitude_pid_thrust_core_test.sv
